// ===== rtl/core/pngup_pkg.sv =====
package pngup_pkg;

  localparam int MAX_ROW_BYTES_DEF = 8192;

  localparam int SAMPLE_W      = 16;
  localparam int ROW_SAMPLES_W = 13;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 13;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_SAMPLES  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_16BIT = 1'b1;

  localparam logic [7:0] UP_FILTER_TYPE = 8'd2;

  localparam int QUEUE_DEPTH = 4;

  // one classified sample, handed from the front to the back
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       two;
    logic       first_row;
    logic       need_filter;
    logic       row_end;
  } pngup_cmd_t;

endpackage

// ===== rtl/core/pngup_if.sv =====
interface pngup_in_if import pngup_pkg::*;;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                image_start;

  modport source (output valid, output sample, output image_start, input ready);
  modport sink (input valid, input sample, input image_start, output ready);
endinterface

interface pngup_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_filter_byte;
  logic       end_of_row;
  logic       last;

  modport source (output valid, output out_byte, output is_filter_byte,
                  output end_of_row, output last, input ready);
  modport sink (input valid, input out_byte, input is_filter_byte,
                input end_of_row, input last, output ready);
endinterface

interface pngup_cfg_if import pngup_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/pngup_queue.sv =====
module pngup_queue import pngup_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] head,
  output logic         avail
);

  localparam int DEPTH = QUEUE_DEPTH;
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);

  logic [W-1:0]    slots [DEPTH];
  logic [IW-1:0]   wr_ptr;
  logic [IW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;

  assign full  = (count == CNTW'(DEPTH));
  assign avail = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IW'(DEPTH - 1)) ? '0 : wr_ptr + IW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IW'(DEPTH - 1)) ? '0 : rd_ptr + IW'(1);
      end
      if (push && !pop) begin
        count <= count + CNTW'(1);
      end else if (pop && !push) begin
        count <= count - CNTW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/pngup_front.sv =====
module pngup_front import pngup_pkg::*; #(
  parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  pngup_in_if.sink                           samples,
  pngup_cfg_if.sink                          cfg,
  input  logic                               q_full,
  output logic                               push,
  output logic [$clog2(MAX_ROW_BYTES)-1:0]   push_pos,
  output pngup_cmd_t                         push_cmd
);

  localparam int AW = $clog2(MAX_ROW_BYTES);
  localparam int PW = AW + 1;
  localparam int CW = ((PW > ROW_SAMPLES_W) ? PW : ROW_SAMPLES_W) + 1;
  localparam logic [CW-1:0] CAP1 = CW'(MAX_ROW_BYTES);
  localparam logic [CW-1:0] CAP2 = CW'(MAX_ROW_BYTES / 2);

  logic [ROW_SAMPLES_W-1:0] row_samples;
  logic                     sample_16bit;
  logic [PW-1:0]            byte_position;
  logic                     in_first_row;

  logic [ROW_SAMPLES_W-1:0] s_eff;
  logic [CW-1:0]            s_ext;
  logic [CW-1:0]            clamp;
  logic [PW-1:0]            row_bytes;
  logic [PW:0]              bpp_ext;
  logic [PW-1:0]            pos0;
  logic [PW-1:0]            pos1;
  logic                     first0;
  logic                     first1;
  logic                     overrun;
  logic                     row_end;

  always_comb begin
    s_eff = (row_samples == '0) ? ROW_SAMPLES_W'(1) : row_samples;
    s_ext = CW'(s_eff);
    if (sample_16bit) begin
      clamp     = (s_ext > CAP2) ? CAP2 : s_ext;
      row_bytes = PW'({clamp, 1'b0});
    end else begin
      clamp     = (s_ext > CAP1) ? CAP1 : s_ext;
      row_bytes = PW'(clamp);
    end
    bpp_ext = sample_16bit ? (PW + 1)'(2) : (PW + 1)'(1);

    pos0   = samples.image_start ? '0 : byte_position;
    first0 = samples.image_start ? 1'b1 : in_first_row;
    // a sample that no longer fits the row drops the partial row
    overrun = (({1'b0, pos0} + bpp_ext) > {1'b0, row_bytes});
    pos1    = overrun ? '0 : pos0;
    first1  = overrun ? 1'b0 : first0;
    row_end = (({1'b0, pos1} + bpp_ext) >= {1'b0, row_bytes});
  end

  assign samples.ready = !q_full;
  assign cfg.ready     = 1'b1;
  assign push          = samples.valid && !q_full;
  assign push_pos      = pos1[AW-1:0];

  always_comb begin
    push_cmd.byte0       = sample_16bit ? samples.sample[15:8] : samples.sample[7:0];
    push_cmd.byte1       = samples.sample[7:0];
    push_cmd.two         = sample_16bit;
    push_cmd.first_row   = first1;
    push_cmd.need_filter = (pos1 == '0);
    push_cmd.row_end     = row_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_samples   <= ROW_SAMPLES_W'(1);
      sample_16bit  <= 1'b0;
      byte_position <= '0;
      in_first_row  <= 1'b1;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_ROW_SAMPLES:  row_samples  <= cfg.data[ROW_SAMPLES_W-1:0];
          REG_SAMPLE_16BIT: sample_16bit <= cfg.data[0];
        endcase
      end
      if (push) begin
        if (row_end) begin
          byte_position <= '0;
          in_first_row  <= 1'b0;
        end else begin
          byte_position <= PW'({1'b0, pos1} + bpp_ext);
          in_first_row  <= first1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/pngup_back.sv =====
module pngup_back import pngup_pkg::*; #(
  parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               avail,
  input  logic [$clog2(MAX_ROW_BYTES)-1:0]   head_pos,
  input  pngup_cmd_t                         head_cmd,
  output logic                               pop,
  pngup_out_if.source                        scan
);

  localparam int AW = $clog2(MAX_ROW_BYTES);
  localparam int PW = AW + 1;

  logic [7:0]    line_mem [MAX_ROW_BYTES];
  logic [7:0]    rd_data;
  logic [PW-1:0] fill;

  logic          sent_filt;
  logic          sent_b0;

  logic          b_valid;
  logic [7:0]    b_raw;
  logic          b_zero;
  logic          b_filt;
  logic          b_eor;
  logic          b_last;

  logic          step_filt;
  logic          step_b1;
  logic          step_last;
  logic          advance;
  logic          mem_en;
  logic [AW-1:0] acc_addr;
  logic [7:0]    acc_raw;
  logic          unwritten;

  always_comb begin
    step_filt = head_cmd.need_filter && !sent_filt;
    step_b1   = !step_filt && sent_b0;
    step_last = !step_filt && (step_b1 || !head_cmd.two);
    advance   = avail && (!b_valid || scan.ready);
    mem_en    = advance && !step_filt;
    acc_addr  = step_b1 ? head_pos + AW'(1) : head_pos;
    acc_raw   = step_b1 ? head_cmd.byte1 : head_cmd.byte0;
    // entries at or past the fill mark have not been written since reset
    unwritten = ({1'b0, acc_addr} >= fill);
  end

  assign pop = advance && step_last;

  // read returns the previous row's byte, then the new byte replaces it
  always_ff @(posedge clk) begin
    if (mem_en) begin
      rd_data            <= line_mem[acc_addr];
      line_mem[acc_addr] <= acc_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      sent_filt <= 1'b0;
      sent_b0   <= 1'b0;
      fill      <= '0;
    end else begin
      if (advance) begin
        b_valid <= 1'b1;
      end else if (scan.ready) begin
        b_valid <= 1'b0;
      end
      if (advance) begin
        if (step_last) begin
          sent_filt <= 1'b0;
          sent_b0   <= 1'b0;
        end else if (step_filt) begin
          sent_filt <= 1'b1;
        end else begin
          sent_b0 <= 1'b1;
        end
      end
      if (mem_en && unwritten) begin
        fill <= PW'({1'b0, acc_addr} + PW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_raw  <= step_filt ? UP_FILTER_TYPE : acc_raw;
      b_zero <= step_filt || head_cmd.first_row || unwritten;
      b_filt <= step_filt;
      b_eor  <= step_last && head_cmd.row_end;
      b_last <= step_last;
    end
  end

  assign scan.valid          = b_valid;
  assign scan.out_byte       = b_raw - (b_zero ? 8'd0 : rd_data);
  assign scan.is_filter_byte = b_filt;
  assign scan.end_of_row     = b_eor;
  assign scan.last           = b_last;

endmodule

// ===== rtl/core/png_up_filter_scanline_core.sv =====
// PNG Up filter scanline core.
// samples: one channel sample per request, in row order; image_start marks
//   the first sample of an image and restarts the row with an all-zero prior row.
// scan: one byte per request; each row opens with a filter type byte of 2,
//   then big-endian filtered data bytes (one per sample in 8-bit mode, two in
//   16-bit mode); last marks the final byte caused by one sample.
// cfg: register 0 is row_samples, register 1 is sample_16bit; write only
//   while no sample is in flight.
// A sample passes through the queue and then the output byte register before its first byte is valid.
// The back end sends one byte per cycle while scan.ready is high; a sample yields
//   1 to 3 bytes (filter byte plus one or two data bytes).
// A four-entry queue sits between the classifier and the byte sequencer.
// Reset: row_samples 1, 8-bit mode, first-row state; a fill mark makes unwritten
//   line store entries read as zero, so samples are taken right after reset.
// When scan.ready is low the output byte holds, the queue fills and
//   samples.ready drops once it is full.
module png_up_filter_scanline_core import pngup_pkg::*; #(
  parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  pngup_in_if.sink    samples,
  pngup_out_if.source scan,
  pngup_cfg_if.sink   cfg
);

  localparam int AW = $clog2(MAX_ROW_BYTES);
  localparam int QW = AW + $bits(pngup_cmd_t);

  logic          q_full;
  logic          push;
  logic [AW-1:0] push_pos;
  pngup_cmd_t    push_cmd;
  logic          pop;
  logic          avail;
  logic [QW-1:0] head;
  logic [AW-1:0] head_pos;
  pngup_cmd_t    head_cmd;

  pngup_front #(
    .MAX_ROW_BYTES(MAX_ROW_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples),
    .cfg      (cfg),
    .q_full   (q_full),
    .push     (push),
    .push_pos (push_pos),
    .push_cmd (push_cmd)
  );

  pngup_queue #(
    .W(QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_pos, push_cmd}),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .avail     (avail)
  );

  assign head_pos = head[QW-1:$bits(pngup_cmd_t)];
  assign head_cmd = pngup_cmd_t'(head[$bits(pngup_cmd_t)-1:0]);

  pngup_back #(
    .MAX_ROW_BYTES(MAX_ROW_BYTES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .avail    (avail),
    .head_pos (head_pos),
    .head_cmd (head_cmd),
    .pop      (pop),
    .scan     (scan)
  );

endmodule

// ===== tb/tb_png_up_filter_scanline_core.sv =====
module tb_png_up_filter_scanline_core;
  timeunit 1ns;
  timeprecision 1ps;

  import pngup_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_WAIT  = 20;
  localparam int RANDOM_REQS = 80;

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic                image_start;
  } sample_req_t;

  typedef struct {
    logic [7:0] out_byte;
    logic       is_filter_byte;
    logic       end_of_row;
    logic       last;
  } scan_byte_t;

  logic clk;
  logic rst;

  pngup_in_if  samples_if ();
  pngup_out_if scan_if ();
  pngup_cfg_if cfg_if ();

  png_up_filter_scanline_core uut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .scan    (scan_if),
    .cfg     (cfg_if)
  );

  // shadow of the filter state
  logic [7:0]            line_mem [MAX_ROW_BYTES_DEF];
  int unsigned           line_pos;
  bit                    first_row;
  logic [CFG_DATA_W-1:0] cfg_rows;
  bit                    cfg_wide;

  sample_req_t pending_samples[$];
  scan_byte_t  exp_bytes[$];
  int          n_queued;
  int          n_taken;
  int          mismatches;
  bit          no_gaps;
  int          send_gap;
  int          recv_gap;
  int          quiet_cycles;

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic void push_scan_byte(logic [7:0] b, logic filt, logic eor);
    scan_byte_t r;
    r.out_byte       = b;
    r.is_filter_byte = filt;
    r.end_of_row     = eor;
    r.last           = 1'b0;
    exp_bytes.insert(exp_bytes.size(), r);
  endfunction

  // up filter: each data byte minus the byte above it
  function automatic void predict_up_bytes(logic [SAMPLE_W-1:0] smp, logic img_start);
    int unsigned bpp;
    int unsigned cap;
    int unsigned rs;
    int unsigned row_len;
    logic [7:0]  raw [2];
    logic [7:0]  above;
    logic        eor;
    bpp = cfg_wide ? 2 : 1;
    cap = MAX_ROW_BYTES_DEF / bpp;
    rs = (cfg_rows == 0) ? 1 : cfg_rows;
    if (rs > cap) rs = cap;
    row_len = rs * bpp;
    if (img_start) begin
      line_pos  = 0;
      first_row = 1'b1;
    end
    // sample does not fit the rest of the row: start over on a new row
    if (line_pos + bpp > row_len) begin
      line_pos  = 0;
      first_row = 1'b0;
    end
    raw[0] = cfg_wide ? smp[15:8] : smp[7:0];
    raw[1] = smp[7:0];
    if (line_pos == 0) push_scan_byte(UP_FILTER_TYPE, 1'b1, 1'b0);
    for (int k = 0; k < bpp; k++) begin
      above = first_row ? 8'd0 : line_mem[line_pos];
      line_mem[line_pos] = raw[k];
      line_pos++;
      eor = (line_pos >= row_len);
      push_scan_byte(raw[k] - above, 1'b0, eor);
      if (eor) begin
        line_pos  = 0;
        first_row = 1'b0;
      end
    end
    exp_bytes[exp_bytes.size() - 1].last = 1'b1;
  endfunction

  // sample driver
  always @(posedge clk) begin
    sample_req_t req;
    if (rst) begin
      samples_if.valid       <= 1'b0;
      samples_if.sample      <= '0;
      samples_if.image_start <= 1'b0;
      send_gap = 0;
    end else begin
      if (samples_if.valid && samples_if.ready) begin
        predict_up_bytes(samples_if.sample, samples_if.image_start);
        n_taken++;
      end
      if (samples_if.valid && !samples_if.ready) begin
        // hold the request until taken
      end else if (send_gap > 0) begin
        send_gap--;
        samples_if.valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        req = pending_samples.pop_front();
        samples_if.valid       <= 1'b1;
        samples_if.sample      <= req.sample;
        samples_if.image_start <= req.image_start;
        if (!no_gaps && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 4);
      end else begin
        samples_if.valid <= 1'b0;
      end
    end
  end

  // scan byte monitor
  always @(posedge clk) begin
    scan_byte_t want;
    if (rst) begin
      scan_if.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (scan_if.valid && scan_if.ready) begin
        if (exp_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected byte %h filt %b eor %b last %b", $realtime,
                     scan_if.out_byte, scan_if.is_filter_byte, scan_if.end_of_row,
                     scan_if.last);
        end else begin
          want = exp_bytes.pop_front();
          if (scan_if.out_byte !== want.out_byte ||
              scan_if.is_filter_byte !== want.is_filter_byte ||
              scan_if.end_of_row !== want.end_of_row ||
              scan_if.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: byte exp %h/%b/%b/%b got %h/%b/%b/%b (byte/filt/eor/last)",
                       $realtime, want.out_byte, want.is_filter_byte, want.end_of_row,
                       want.last, scan_if.out_byte, scan_if.is_filter_byte,
                       scan_if.end_of_row, scan_if.last);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        scan_if.ready <= 1'b0;
      end else begin
        scan_if.ready <= 1'b1;
        if (!no_gaps && $urandom_range(0, 4) == 0) recv_gap = $urandom_range(1, 4);
      end
    end
  end

  // watchdog on cycles where nothing moves
  always @(posedge clk) begin
    if (rst || (samples_if.valid && samples_if.ready) || (scan_if.valid && scan_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    if (idx == REG_ROW_SAMPLES) cfg_rows = val;
    else cfg_wide = val[0];
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic queue_sample(input logic [SAMPLE_W-1:0] smp, input logic img_start);
    sample_req_t req;
    req.sample      = smp;
    req.image_start = img_start;
    pending_samples.insert(pending_samples.size(), req);
    n_queued++;
  endtask

  task automatic wait_drained();
    while (n_taken != n_queued || exp_bytes.size() != 0) @(posedge clk);
  endtask

  initial begin
    int rnd_count;
    int len;
    int pick;
    int rows;
    clk = 1'b0;
    rst = 1'b1;
    samples_if.valid       = 1'b0;
    samples_if.sample      = '0;
    samples_if.image_start = 1'b0;
    scan_if.ready          = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.index           = REG_ROW_SAMPLES;
    cfg_if.data            = '0;
    foreach (line_mem[i]) line_mem[i] = 8'd0;
    line_pos   = 0;
    first_row  = 1'b1;
    cfg_rows   = 1;
    cfg_wide   = 1'b0;
    n_queued   = 0;
    n_taken    = 0;
    mismatches = 0;
    no_gaps    = 1'b0;
    quiet_cycles = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: one-byte rows, prior row all zero
    queue_sample(16'h00FF, 1'b0);
    queue_sample(16'hFF00, 1'b0);
    wait_drained();

    // zero row length behaves as one sample
    write_reg(REG_ROW_SAMPLES, 13'd0);
    queue_sample(16'h1234, 1'b0);
    queue_sample(16'hFFFF, 1'b0);
    wait_drained();

    // 16-bit rows of three samples, then a new image in the middle of a row
    write_reg(REG_SAMPLE_16BIT, 13'd1);
    write_reg(REG_ROW_SAMPLES, 13'd3);
    queue_sample(16'hFFFF, 1'b1);
    queue_sample(16'h0000, 1'b0);
    queue_sample(16'h8001, 1'b0);
    queue_sample(16'h7FFE, 1'b0);
    queue_sample(16'h0102, 1'b0);
    queue_sample(16'hABCD, 1'b0);
    queue_sample(16'h5555, 1'b0);
    queue_sample(16'h1111, 1'b1);
    queue_sample(16'h2222, 1'b0);
    wait_drained();

    // shorter 8-bit rows while mid-row: partial row is dropped
    write_reg(REG_SAMPLE_16BIT, 13'd0);
    write_reg(REG_ROW_SAMPLES, 13'd2);
    queue_sample(16'hAA33, 1'b0);
    wait_drained();
    write_reg(REG_ROW_SAMPLES, 13'd1);
    queue_sample(16'h5544, 1'b0);
    queue_sample(16'h0080, 1'b0);
    queue_sample(16'h007F, 1'b0);
    wait_drained();

    // a 4096-sample row, partial only
    write_reg(REG_ROW_SAMPLES, 13'd4096);
    queue_sample(16'hC3C3, 1'b1);
    queue_sample(16'h3C3C, 1'b0);
    queue_sample(16'hFFFF, 1'b0);
    wait_drained();

    // oversize row in 16-bit mode saturates to the line store, partial only
    write_reg(REG_SAMPLE_16BIT, 13'd1);
    write_reg(REG_ROW_SAMPLES, 13'h1FFF);
    for (int k = 0; k < 4; k++)
      queue_sample(SAMPLE_W'($urandom), k == 0);
    wait_drained();

    rnd_count = 0;
    while (rnd_count < RANDOM_REQS) begin
      pick = $urandom_range(0, 11);
      if (pick == 0) rows = 0;
      else if (pick == 1) rows = $urandom_range(7, 40);
      else rows = $urandom_range(1, 6);
      if ($urandom_range(0, 3) != 0) write_reg(REG_ROW_SAMPLES, CFG_DATA_W'(rows));
      if ($urandom_range(0, 2) != 0)
        write_reg(REG_SAMPLE_16BIT, CFG_DATA_W'($urandom_range(0, 1)));
      len = $urandom_range(4, 20);
      for (int k = 0; k < len; k++)
        queue_sample(SAMPLE_W'($urandom),
                     (k == 0) ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 19) == 0));
      rnd_count += len;
      wait_drained();
    end

    // closing stretch at full rate
    no_gaps = 1'b1;
    write_reg(REG_SAMPLE_16BIT, 13'd1);
    write_reg(REG_ROW_SAMPLES, 13'd3);
    for (int k = 0; k < 16; k++)
      queue_sample(SAMPLE_W'($urandom), k == 0);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    if (exp_bytes.size() != 0) begin
      mismatches++;
      $display("%0d expected bytes never arrived", exp_bytes.size());
    end
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
